>>> hw/rtl/voxel_cdf_position_sampler_assert.svh
// Assertion macros for the voxel sampler; clocked on clk, quiet while rst_n is low.
`ifndef VOXEL_CDF_POSITION_SAMPLER_ASSERT_SVH
`define VOXEL_CDF_POSITION_SAMPLER_ASSERT_SVH

// same-cycle implication
`define VCPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VCPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/vcps_pkg.sv
package vcps_pkg;

    localparam int SUM_W   = 44;
    localparam int CNT_CW  = 11;
    localparam int PITCH_W = 31;
    localparam int POS_W   = 32;
    localparam int CHOSEN_W = 24;
    localparam int NXY_W   = 10;
    localparam logic [CNT_CW-1:0] MAX_GRID = 11'd1024;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] REG_COUNT_X  = 3'd0;
    localparam logic [2:0] REG_COUNT_Y  = 3'd1;
    localparam logic [2:0] REG_PITCH_X  = 3'd2;
    localparam logic [2:0] REG_PITCH_Y  = 3'd3;
    localparam logic [2:0] REG_PITCH_Z  = 3'd4;
    localparam logic [2:0] REG_ORIGIN_X = 3'd5;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd6;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_TGT,
        S_RD,
        S_CMP,
        S_IDX,
        S_DIV,
        S_MULP,
        S_POS
    } state_t;

    function automatic logic [CNT_CW-1:0] clamp_grid(input logic [CNT_CW-1:0] c);
        logic [CNT_CW-1:0] r;
        r = c;
        if (c == '0)
            r = CNT_CW'(1);
        else if (c > MAX_GRID)
            r = MAX_GRID;
        return r;
    endfunction

    // origin + product, saturated at the positive limit (product is never negative)
    function automatic logic [POS_W-1:0] place_sat(input logic [POS_W-1:0] org,
                                                   input logic [63:0] prod);
        logic [65:0] sum;
        logic [POS_W-1:0] r;
        sum = {{34{org[POS_W-1]}}, org} + {2'b00, prod};
        if (!sum[65] && (|sum[64:31]))
            r = 32'h7FFF_FFFF;
        else
            r = sum[31:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/voxel_cdf_position_sampler.sv
// Channel  Direction  Handshake           Payload
// in       into       in_valid/in_stall   action, weight, voxel_index, random_fraction
// out      out of     out_valid/out_stall status, chosen_index, index_x/y/z, pos_x/y/z
// cfg      into       cfg_we              cfg_index, cfg_data
//
// Clear and append finish in the accept cycle; their item lands in the output register.
// A sample runs a binary search on the table memory, each step a registered read (S_RD)
// then a compare (S_CMP), then a one-bit-per-cycle divider run twice (by count_x, count_y).
// rst_n clears the fill count, running total and control and sets config to its defaults;
// table contents are undefined until written. A held output item does not block a sample
// from being taken.
module voxel_cdf_position_sampler #(
    parameter int TABLE_DEPTH = 4096,
    parameter int INDEX_BITS  = 24
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] weight,
    input  logic [23:0] voxel_index,
    input  logic [31:0] random_fraction,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [23:0] chosen_index,
    output logic [9:0]  index_x,
    output logic [9:0]  index_y,
    output logic [23:0] index_z,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SW   = vcps_pkg::SUM_W;
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = AW + 1;
    localparam int IB   = INDEX_BITS;
    localparam int MW   = SW + IB;
    localparam int STW  = $clog2(INDEX_BITS);
    localparam int NW   = vcps_pkg::NXY_W;
    localparam int GW   = vcps_pkg::CNT_CW;

    // config registers
    logic [GW-1:0] count_x_reg, count_y_reg;
    logic [30:0]   pitch_x_reg, pitch_y_reg, pitch_z_reg;
    logic [31:0]   origin_x_reg, origin_y_reg, origin_z_reg;

    // control
    vcps_pkg::state_t state_reg, state_next;
    logic [CW-1:0] entry_count_reg;
    logic [SW-1:0] total_reg;
    logic          out_valid_reg;

    // table memory: {cumulative sum, voxel index}
    logic [MW-1:0] table_mem [TABLE_DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // sample datapath
    logic [31:0]   rnd_reg;
    logic [63:0]   plo_reg;
    logic [43:0]   phi_reg;
    logic [SW-1:0] target_reg;
    logic [AW-1:0] lo_reg, hi_reg, mid_reg, mid;
    logic [IB-1:0] chosen_reg, quo_reg, nz_reg;
    logic [NW-1:0] rem_reg, nx_reg, ny_reg;
    logic [GW-1:0] dvs_reg;
    logic [STW-1:0] step_reg;
    logic          pass_reg;
    logic [63:0]   prod_x_reg, prod_y_reg, prod_z_reg;

    // output payload
    logic [1:0]  status_reg;
    logic [23:0] chosen_index_reg, index_z_reg;
    logic [9:0]  index_x_reg, index_y_reg;
    logic [31:0] pos_x_reg, pos_y_reg, pos_z_reg;

    logic in_acc, out_acc, empty, full, need_slot, slot_free;
    logic [SW:0]   sum_wide;
    logic [SW-1:0] sum_sat;
    logic [GW-1:0] cx, cy;
    logic [GW-1:0] shifted;
    logic          ge;
    logic [NW-1:0] new_rem;
    logic [IB-1:0] new_quo;
    logic [31:0]   chosen_w, nz_w;

    assign empty     = (entry_count_reg == '0) || (total_reg == '0);
    assign full      = (entry_count_reg >= CW'(TABLE_DEPTH));
    assign slot_free = !out_valid_reg || !out_stall;
    assign need_slot = !((action == vcps_pkg::ACT_SAMPLE) && !empty);
    assign in_stall  = (state_reg != vcps_pkg::S_IDLE) || (need_slot && !slot_free);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;

    assign sum_wide = {1'b0, total_reg} + {{(SW + 1 - 32){1'b0}}, weight};
    assign sum_sat  = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
    assign mem_we   = in_acc && (action == vcps_pkg::ACT_APPEND) && (weight != '0) && !full;

    assign cx  = vcps_pkg::clamp_grid(count_x_reg);
    assign cy  = vcps_pkg::clamp_grid(count_y_reg);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_addr = (lo_reg < hi_reg) ? mid : lo_reg;

    // restoring divider step: remainder stays below the divisor (<= 1024)
    assign shifted = {rem_reg, quo_reg[IB-1]};
    assign ge      = (shifted >= dvs_reg);
    assign new_rem = ge ? NW'(shifted - dvs_reg) : NW'(shifted);
    assign new_quo = {quo_reg[IB-2:0], ge};

    assign chosen_w = 32'(chosen_reg);
    assign nz_w     = 32'(nz_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[entry_count_reg[AW-1:0]] <= {sum_sat, IB'(voxel_index)};
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vcps_pkg::S_IDLE;
            count_x_reg  <= GW'(1);
            count_y_reg  <= GW'(1);
            pitch_x_reg  <= 31'd65536;
            pitch_y_reg  <= 31'd65536;
            pitch_z_reg  <= 31'd65536;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    vcps_pkg::REG_COUNT_X:  count_x_reg  <= cfg_data[GW-1:0];
                    vcps_pkg::REG_COUNT_Y:  count_y_reg  <= cfg_data[GW-1:0];
                    vcps_pkg::REG_PITCH_X:  pitch_x_reg  <= cfg_data[30:0];
                    vcps_pkg::REG_PITCH_Y:  pitch_y_reg  <= cfg_data[30:0];
                    vcps_pkg::REG_PITCH_Z:  pitch_z_reg  <= cfg_data[30:0];
                    vcps_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                    vcps_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    vcps_pkg::REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // table bookkeeping and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // a new item always lands in a free slot
            if ((in_acc && need_slot) || ((state_reg == vcps_pkg::S_POS) && slot_free))
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
            if (in_acc && (action == vcps_pkg::ACT_CLEAR))
            begin
                entry_count_reg <= '0;
                total_reg       <= '0;
            end
            if (mem_we)
            begin
                entry_count_reg <= entry_count_reg + CW'(1);
                total_reg       <= sum_sat;
            end
        end
    end

    // sample datapath and output payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            vcps_pkg::S_IDLE:
            begin
                rnd_reg <= random_fraction;
                if (in_acc && need_slot)
                begin
                    if ((action == vcps_pkg::ACT_APPEND) && (weight != '0) && full)
                        status_reg <= vcps_pkg::ST_FULL;
                    else if (action == vcps_pkg::ACT_SAMPLE)
                        status_reg <= vcps_pkg::ST_EMPTY;
                    else
                        status_reg <= vcps_pkg::ST_OK;
                    chosen_index_reg <= '0;
                    index_x_reg      <= '0;
                    index_y_reg      <= '0;
                    index_z_reg      <= '0;
                    pos_x_reg        <= '0;
                    pos_y_reg        <= '0;
                    pos_z_reg        <= '0;
                end
            end
            vcps_pkg::S_MUL:
            begin
                plo_reg <= total_reg[31:0] * rnd_reg;
                phi_reg <= total_reg[SW-1:32] * rnd_reg;
            end
            vcps_pkg::S_TGT:
            begin
                // floor(total * rnd / 2^32), below total so it fits
                target_reg <= SW'(phi_reg + {12'd0, plo_reg[63:32]});
                lo_reg     <= '0;
                hi_reg     <= AW'(entry_count_reg - CW'(1));
            end
            vcps_pkg::S_RD:
                mid_reg <= mid;
            vcps_pkg::S_CMP:
            begin
                if (rd_data_reg[MW-1:IB] > target_reg)
                    hi_reg <= mid_reg;
                else
                    lo_reg <= mid_reg + AW'(1);
            end
            vcps_pkg::S_IDX:
            begin
                chosen_reg <= rd_data_reg[IB-1:0];
                quo_reg    <= rd_data_reg[IB-1:0];
                rem_reg    <= '0;
                dvs_reg    <= cx;
                step_reg   <= STW'(IB - 1);
                pass_reg   <= 1'b0;
            end
            vcps_pkg::S_DIV:
            begin
                quo_reg <= new_quo;
                if ((step_reg == '0) && !pass_reg)
                begin
                    // first pass done: remainder is x, quotient goes on to the y pass
                    nx_reg   <= new_rem;
                    rem_reg  <= '0;
                    dvs_reg  <= cy;
                    step_reg <= STW'(IB - 1);
                    pass_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= new_rem;
                    step_reg <= step_reg - STW'(1);
                    if (step_reg == '0)
                    begin
                        ny_reg <= new_rem;
                        nz_reg <= new_quo;
                    end
                end
            end
            vcps_pkg::S_MULP:
            begin
                prod_x_reg <= 64'(pitch_x_reg * 41'(nx_reg));
                prod_y_reg <= 64'(pitch_y_reg * 41'(ny_reg));
                prod_z_reg <= 64'(64'(pitch_z_reg) * 64'(nz_reg));
            end
            vcps_pkg::S_POS:
            begin
                if (slot_free)
                begin
                    status_reg       <= vcps_pkg::ST_OK;
                    chosen_index_reg <= chosen_w[23:0];
                    index_x_reg      <= nx_reg;
                    index_y_reg      <= ny_reg;
                    index_z_reg      <= nz_w[23:0];
                    pos_x_reg <= vcps_pkg::place_sat(origin_x_reg, prod_x_reg);
                    pos_y_reg <= vcps_pkg::place_sat(origin_y_reg, prod_y_reg);
                    pos_z_reg <= vcps_pkg::place_sat(origin_z_reg, prod_z_reg);
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vcps_pkg::S_IDLE:
                if (in_acc && !need_slot)
                    state_next = vcps_pkg::S_MUL;
            vcps_pkg::S_MUL:  state_next = vcps_pkg::S_TGT;
            vcps_pkg::S_TGT:  state_next = vcps_pkg::S_RD;
            vcps_pkg::S_RD:
                state_next = (lo_reg < hi_reg) ? vcps_pkg::S_CMP : vcps_pkg::S_IDX;
            vcps_pkg::S_CMP:  state_next = vcps_pkg::S_RD;
            vcps_pkg::S_IDX:  state_next = vcps_pkg::S_DIV;
            vcps_pkg::S_DIV:
                if ((step_reg == '0) && pass_reg)
                    state_next = vcps_pkg::S_MULP;
            vcps_pkg::S_MULP: state_next = vcps_pkg::S_POS;
            vcps_pkg::S_POS:
                if (slot_free)
                    state_next = vcps_pkg::S_IDLE;
            default: state_next = vcps_pkg::S_IDLE;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_index_reg;
    assign index_x      = index_x_reg;
    assign index_y      = index_y_reg;
    assign index_z      = index_z_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;

`include "voxel_cdf_position_sampler_assert.svh"

    `VCPS_ASSERT_NOW(a_count_bound, 1'b1, entry_count_reg <= CW'(TABLE_DEPTH), "fill count past depth")
    `VCPS_ASSERT_NOW(a_search_order, state_reg == vcps_pkg::S_CMP, lo_reg < hi_reg, "search bounds crossed")
    `VCPS_ASSERT_NOW(a_div_rem, state_reg == vcps_pkg::S_DIV, rem_reg < dvs_reg, "remainder not below divisor")
    `VCPS_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg, "held item dropped")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = 4096;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] weight;
    logic [23:0] voxel_index;
    logic [31:0] random_fraction;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [23:0] chosen_index;
    logic [9:0]  index_x;
    logic [9:0]  index_y;
    logic [23:0] index_z;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // one expected status item
    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] chosen;
        logic [9:0]  nx;
        logic [9:0]  ny;
        logic [23:0] nz;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } draw_t;

    draw_t pending_draws[$];

    // shadow of the table and registers
    logic [43:0] shadow_cum[DEPTH];
    logic [23:0] shadow_idx[DEPTH];
    int          shadow_fill;
    logic [43:0] shadow_total;
    logic [10:0] sh_count_x, sh_count_y;
    logic [30:0] sh_pitch[3];
    logic [31:0] sh_origin[3];

    int errors;
    int items_sent;
    int draws_checked;
    int samples_sent;
    int send_idle_pct;   // sender idle chance in percent
    int stall_pct;       // receiver stall chance in percent

    voxel_cdf_position_sampler i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .weight(weight), .voxel_index(voxel_index),
        .random_fraction(random_fraction),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .chosen_index(chosen_index),
        .index_x(index_x), .index_y(index_y), .index_z(index_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // origin plus pitch * n, saturating at the positive limit only
    function automatic logic [31:0] axis_pos(input logic [31:0] org, input logic [30:0] pitch,
                                             input logic [23:0] n);
        logic signed [66:0] sum;
        sum = $signed({{35{org[31]}}, org}) + $signed(67'({36'd0, pitch}) * 67'(n));
        if (sum > 67'sd2147483647)
            return 32'h7FFF_FFFF;
        return sum[31:0];
    endfunction

    // predict the status item of one action and update the shadow table
    function automatic draw_t predict_action(input logic [1:0] act, input logic [31:0] w,
                                             input logic [23:0] vidx, input logic [31:0] rnd);
        draw_t d;
        logic [75:0] scaled;
        logic [43:0] target;
        int lo, hi, mid;
        logic [23:0] pick;
        logic [10:0] cx, cy;
        d = '0;
        if (act == vcps_pkg::ACT_CLEAR) begin
            shadow_fill = 0;
            shadow_total = '0;
        end else if (act == vcps_pkg::ACT_APPEND) begin
            if (w != 0) begin
                if (shadow_fill >= DEPTH) begin
                    d.status = vcps_pkg::ST_FULL;
                end else begin
                    shadow_total = shadow_total + 44'(w);
                    shadow_cum[shadow_fill] = shadow_total;
                    shadow_idx[shadow_fill] = vidx;
                    shadow_fill++;
                end
            end
        end else if (act == vcps_pkg::ACT_SAMPLE) begin
            if (shadow_fill == 0 || shadow_total == 0) begin
                d.status = vcps_pkg::ST_EMPTY;
            end else begin
                // exact floor(total * rnd / 2^32)
                scaled = 76'(shadow_total) * 76'(rnd);
                target = scaled[75:32];
                lo = 0;
                hi = shadow_fill - 1;
                while (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (shadow_cum[mid] > target) hi = mid;
                    else lo = mid + 1;
                end
                pick = shadow_idx[lo];
                cx = (sh_count_x == 0) ? 11'd1 : (sh_count_x > 11'd1024 ? 11'd1024 : sh_count_x);
                cy = (sh_count_y == 0) ? 11'd1 : (sh_count_y > 11'd1024 ? 11'd1024 : sh_count_y);
                d.chosen = pick;
                d.nx = 10'(pick % cx);
                d.ny = 10'((pick / cx) % cy);
                d.nz = 24'(pick / (32'(cx) * 32'(cy)));
                d.px = axis_pos(sh_origin[0], sh_pitch[0], 24'(pick % cx));
                d.py = axis_pos(sh_origin[1], sh_pitch[1], 24'((pick / cx) % cy));
                d.pz = axis_pos(sh_origin[2], sh_pitch[2], d.nz);
            end
        end
        return d;
    endfunction

    // send one item; the sender may idle first. Valid stays up after the
    // accept: the caller either sends again or drains in the same step.
    task automatic send_item(input logic [1:0] act, input logic [31:0] w,
                             input logic [23:0] vidx, input logic [31:0] rnd);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        weight <= w;
        voxel_index <= vidx;
        random_fraction <= rnd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_draws.push_back(predict_action(act, w, vidx, rnd));
        items_sent++;
        if (act == vcps_pkg::ACT_SAMPLE) samples_sent++;
    endtask

    // let everything drain, then a margin for any work still in flight
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_draws.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            vcps_pkg::REG_COUNT_X:  sh_count_x = val[10:0];
            vcps_pkg::REG_COUNT_Y:  sh_count_y = val[10:0];
            vcps_pkg::REG_PITCH_X:  sh_pitch[0] = val[30:0];
            vcps_pkg::REG_PITCH_Y:  sh_pitch[1] = val[30:0];
            vcps_pkg::REG_PITCH_Z:  sh_pitch[2] = val[30:0];
            vcps_pkg::REG_ORIGIN_X: sh_origin[0] = val;
            vcps_pkg::REG_ORIGIN_Y: sh_origin[1] = val;
            vcps_pkg::REG_ORIGIN_Z: sh_origin[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] p0, input logic [31:0] p1, input logic [31:0] p2,
                            input logic [31:0] o0, input logic [31:0] o1, input logic [31:0] o2);
        drain();
        write_reg(vcps_pkg::REG_COUNT_X, cx);
        write_reg(vcps_pkg::REG_COUNT_Y, cy);
        write_reg(vcps_pkg::REG_PITCH_X, p0);
        write_reg(vcps_pkg::REG_PITCH_Y, p1);
        write_reg(vcps_pkg::REG_PITCH_Z, p2);
        write_reg(vcps_pkg::REG_ORIGIN_X, o0);
        write_reg(vcps_pkg::REG_ORIGIN_Y, o1);
        write_reg(vcps_pkg::REG_ORIGIN_Z, o2);
        cfg_we <= 1'b0;
    endtask

    // directed: empty sample, zero weight, unused code, field extremes
    task automatic test_directed();
        send_item(vcps_pkg::ACT_SAMPLE, 32'd5, 24'd7, 32'hFFFF_FFFF);      // empty table
        send_item(vcps_pkg::ACT_APPEND, 32'd0, 24'hFF_FFFF, 32'd0);        // zero weight
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'd0);              // still empty
        send_item(2'd3, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);        // unused code
        send_item(vcps_pkg::ACT_APPEND, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd0);
        send_item(vcps_pkg::ACT_APPEND, 32'd1, 24'd0, 32'd0);
        send_item(vcps_pkg::ACT_APPEND, 32'd3, 24'h12_3456, 32'd0);
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'd0);
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'hFFFF_FFFF);
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'h8000_0000);
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'h0000_FFFF);
        send_item(vcps_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'h1234_5678);      // empty after clear
        send_item(vcps_pkg::ACT_APPEND, 32'd10, 24'd5, 32'd0);
        send_item(vcps_pkg::ACT_SAMPLE, 32'd0, 24'd0, 32'h4000_0000);
        send_item(vcps_pkg::ACT_CLEAR, 32'd0, 24'd0, 32'd0);
    endtask

    // short well-formed tables with random content, plus some noise;
    // count is the number of items to send
    task automatic test_random(input int count);
        int start, n;
        logic [31:0] w;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(9) == 0) begin
                send_item(2'($urandom), $urandom, 24'($urandom), $urandom);
            end else begin
                send_item(vcps_pkg::ACT_CLEAR, $urandom, 24'($urandom), $urandom);
                n = $urandom_range(1, 12);
                repeat (n) begin
                    w = ($urandom_range(5) == 0) ? 32'd0 :
                        ($urandom_range(1) ? $urandom : 32'($urandom_range(1, 50)));
                    send_item(vcps_pkg::ACT_APPEND, w, 24'($urandom), $urandom);
                end
                n = $urandom_range(1, 6);
                repeat (n) send_item(vcps_pkg::ACT_SAMPLE, $urandom, 24'($urandom), $urandom);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        draw_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_draws.size() == 0) begin
                $display("%0t: unexpected item status=%0d", $time, status);
                errors++;
            end else begin
                e = pending_draws.pop_front();
                draws_checked++;
                if (status !== e.status || chosen_index !== e.chosen || index_x !== e.nx ||
                    index_y !== e.ny || index_z !== e.nz || pos_x !== e.px ||
                    pos_y !== e.py || pos_z !== e.pz) begin
                    $display("%0t: mismatch expected st=%0d idx=%h xyz=%0d/%0d/%0d pos=%h/%h/%h",
                             $time, e.status, e.chosen, e.nx, e.ny, e.nz, e.px, e.py, e.pz);
                    $display("%0t:          actual   st=%0d idx=%h xyz=%0d/%0d/%0d pos=%h/%h/%h",
                             $time, status, chosen_index, index_x, index_y, index_z,
                             pos_x, pos_y, pos_z);
                    errors++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        in_valid = 1'b0;
        action = '0;
        weight = '0;
        voxel_index = '0;
        random_fraction = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_stall = 1'b0;
        errors = 0;
        items_sent = 0;
        draws_checked = 0;
        samples_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        shadow_fill = 0;
        shadow_total = '0;
        sh_count_x = 11'd1;
        sh_count_y = 11'd1;
        sh_pitch[0] = 31'd65536;
        sh_pitch[1] = 31'd65536;
        sh_pitch[2] = 31'd65536;
        sh_origin[0] = '0;
        sh_origin[1] = '0;
        sh_origin[2] = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        test_directed();
        set_grid(32'd4, 32'd3, 32'h0001_8000, 32'h7FFF_FFFF, 32'd0,
                 32'hFFF0_0000, 32'h7000_0000, 32'h8000_0000);
        test_directed();
        test_random(380);

        // pause until all results are back, then go on
        drain();
        send_idle_pct = 66;
        set_grid(32'd1024, 32'd1024, 32'd1, 32'h7FFF_FFFF, 32'h0000_0100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        test_random(380);

        // out-of-range counts: zero and above the maximum
        send_idle_pct = 0;
        stall_pct = 66;
        set_grid(32'd0, 32'd2047, 32'h7FFF_FFFF, 32'd0, 32'd1,
                 32'd0, 32'hFFFF_FFFF, 32'h7FFF_0000);
        test_random(380);

        send_idle_pct = 35;
        stall_pct = 35;
        set_grid(32'd7, 32'd1, 32'h0000_4000, 32'h0002_0000, 32'h0100_0000,
                 32'h8000_0000, 32'h0000_0001, 32'hC000_0000);
        test_random(300);

        send_idle_pct = 0;
        stall_pct = 0;
        set_grid(32'd1, 32'd1, 32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0);
        test_random(80);

        drain();
        $display("Sent %0d items (%0d samples), checked %0d status items",
                 items_sent, samples_sent, draws_checked);
        $display("Covered empty, zero-weight, clamped-grid and saturating cases under stalls");
        if (errors == 0 && pending_draws.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
